FILE: rtl/lscd_pkg.sv
// ----------------------------------------------------------------------------
// lscd_pkg
// Shared constants, types and tables for the laser scan cluster detector.
// ----------------------------------------------------------------------------
package lscd_pkg;

	// Sizes
	localparam int MAX_CLUSTER   = 256;
	localparam int IDX_W         = $clog2(MAX_CLUSTER);
	localparam int CNT_W         = IDX_W + 1;
	localparam int ADDR_W        = IDX_W + 1;
	localparam int RAM_DEPTH     = 2 * MAX_CLUSTER;
	localparam int RANGE_BITS    = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int PHASE_BITS    = 24;
	localparam int CORDIC_STEPS  = 24;
	localparam int COORD_W       = 17;
	localparam int POINT_W       = 2 * COORD_W;
	localparam int SUM_W         = 25;
	localparam int CFG_INDEX_W   = 8;
	localparam int CFG_DATA_W    = 32;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032873;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_JUMP_LIMIT     = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VARIANCE_LIMIT = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_FLOOR    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_CEILING  = 8'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_START_ANGLE    = 8'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP     = 8'd5;

	typedef struct packed {
		logic [15:0] jump_limit_mm;
		logic [31:0] variance_limit_mm2;
		logic [15:0] range_floor_mm;
		logic [15:0] range_ceiling_mm;
		logic [15:0] start_angle;
		logic [15:0] angle_step;
	} cfg_t;

	// Closed cluster handed from front to back
	typedef struct packed {
		logic                    eval;
		logic                    bank;
		logic [CNT_W-1:0]        n;
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic                    item_end;
		logic                    is_end;
	} cmd_t;

	// Bank handed back to the front
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	typedef enum logic [3:0] {
		F_IDLE, F_BAD, F_ROT, F_MUL, F_RND, F_DIST, F_CMP, F_SPLIT, F_PUSH, F_END
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_START, B_DIV, B_RD, B_DIFF, B_SQ, B_SQI, B_SQRT, B_ACC, B_VSQ,
		B_MEANL, B_LIM, B_DEC, B_POST, B_FIN
	} back_state_t;

	// Arctangent per step, 1/2^24 turn
	function automatic logic signed [25:0] cordic_atan(input logic [4:0] i);
		logic signed [25:0] a;
		case (i)
			5'd0:  a = 26'sd2097152;
			5'd1:  a = 26'sd1238021;
			5'd2:  a = 26'sd654136;
			5'd3:  a = 26'sd332050;
			5'd4:  a = 26'sd166669;
			5'd5:  a = 26'sd83416;
			5'd6:  a = 26'sd41718;
			5'd7:  a = 26'sd20860;
			5'd8:  a = 26'sd10430;
			5'd9:  a = 26'sd5215;
			5'd10: a = 26'sd2608;
			5'd11: a = 26'sd1304;
			5'd12: a = 26'sd652;
			5'd13: a = 26'sd326;
			5'd14: a = 26'sd163;
			5'd15: a = 26'sd81;
			5'd16: a = 26'sd41;
			5'd17: a = 26'sd20;
			5'd18: a = 26'sd10;
			5'd19: a = 26'sd5;
			5'd20: a = 26'sd3;
			5'd21: a = 26'sd1;
			5'd22: a = 26'sd1;
			default: a = 26'sd0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/lscd_ram.sv
// ----------------------------------------------------------------------------
// lscd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lscd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/lscd_queue.sv
// ----------------------------------------------------------------------------
// lscd_queue
// Two entry queue of closed clusters between front and back.
// ----------------------------------------------------------------------------
module lscd_queue import lscd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

FILE: rtl/lscd_front.sv
// ----------------------------------------------------------------------------
// lscd_front
// Takes range samples, converts them to x,y with an iterative CORDIC, runs the
// window and jump tests, stores points and hands closed clusters to the back.
// ----------------------------------------------------------------------------
module lscd_front import lscd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [RANGE_BITS-1:0] in_range,
	input  logic                  in_sample_valid,
	input  logic                  in_scan_end,
	output logic                  q_push,
	output cmd_t                  q_cmd,
	input  logic                  q_full,
	input  rel_t                  rel,
	output logic                  ram_we,
	output logic [ADDR_W-1:0]     ram_waddr,
	output logic [POINT_W-1:0]    ram_wdata
);

	front_state_t state_q, state_d;

	// scan and cluster state
	logic                    fresh_q;
	logic [ANGLE_BITS-1:0]   beam_q;
	logic                    have_prev_q;
	logic signed [16:0]      prev_x_q, prev_y_q;
	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;
	logic signed [SUM_W-1:0] sumx_q, sumy_q;
	logic                    bank_q;
	logic [1:0]              busy_q, busy_d;

	// per item datapath
	logic [RANGE_BITS-1:0]   range_q;
	logic                    last_q;
	logic signed [33:0]      c_q, s_q;
	logic signed [25:0]      z_q;
	logic                    flip_q;
	logic [4:0]              it_q;
	logic signed [50:0]      pc_q, ps_q;
	logic signed [16:0]      x_q, y_q;
	logic [31:0]             jj_q;
	logic [35:0]             dx2_q, dy2_q;

	logic                    accept, in_win, close_eval, room, split;
	logic                    issue, clear, push, wr;
	logic [ANGLE_BITS-1:0]   angle;
	logic [PHASE_BITS-1:0]   phase;
	logic signed [25:0]      z0;
	logic signed [33:0]      dc, ds, cf, sf;
	logic signed [25:0]      at;
	logic signed [17:0]      dx, dy;

	function automatic logic signed [16:0] round30(input logic signed [50:0] p);
		logic [50:0] mag;
		logic [50:0] r;
		mag = p[50] ? 51'(-p) : 51'(p);
		r   = (mag + (51'd1 << 29)) >> 30;
		return p[50] ? -$signed(r[16:0]) : $signed(r[16:0]);
	endfunction

	// input decode
	assign accept     = in_valid && in_ready;
	assign in_win     = in_sample_valid && (in_range >= cfg.range_floor_mm)
	                    && (in_range <= cfg.range_ceiling_mm);
	assign angle      = fresh_q ? cfg.start_angle : beam_q;
	assign phase      = {angle, {(PHASE_BITS-ANGLE_BITS){1'b0}}};
	assign z0         = $signed({{2{phase[PHASE_BITS-1]}}, phase});
	assign close_eval = !ovf_q && (count_q >= CNT_W'(2));
	assign room       = count_q < CNT_W'(MAX_CLUSTER);

	// rotation step
	assign dc = s_q >>> it_q;
	assign ds = c_q >>> it_q;
	assign at = cordic_atan(it_q);
	assign cf = flip_q ? -c_q : c_q;
	assign sf = flip_q ? -s_q : s_q;

	// jump test
	assign dx    = {x_q[16], x_q} - {prev_x_q[16], prev_x_q};
	assign dy    = {y_q[16], y_q} - {prev_y_q[16], prev_y_q};
	assign split = ({1'b0, dx2_q} + {1'b0, dy2_q}) > {5'd0, jj_q};

	// closed cluster transaction
	always_comb begin
		q_cmd.eval     = close_eval;
		q_cmd.bank     = bank_q;
		q_cmd.n        = count_q;
		q_cmd.sum_x    = sumx_q;
		q_cmd.sum_y    = sumy_q;
		q_cmd.item_end = last_q;
		q_cmd.is_end   = (state_q == F_END);
	end
	assign q_push = issue;

	assign ram_we    = wr;
	assign ram_waddr = {bank_q, count_q[IDX_W-1:0]};
	assign ram_wdata = {y_q, x_q};

	// next state and control
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		clear    = 1'b0;
		push     = 1'b0;
		wr       = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = in_win ? F_ROT : F_BAD;
			end
			F_BAD, F_SPLIT: begin
				if (!close_eval || !q_full) begin
					clear = 1'b1;
					issue = close_eval;
					if (state_q == F_SPLIT) state_d = F_PUSH;
					else state_d = last_q ? F_END : F_IDLE;
				end
			end
			F_ROT: begin
				if (it_q == 5'(CORDIC_STEPS - 1)) state_d = F_MUL;
			end
			F_MUL:  state_d = F_RND;
			F_RND:  state_d = have_prev_q ? F_DIST : F_PUSH;
			F_DIST: state_d = F_CMP;
			F_CMP:  state_d = split ? F_SPLIT : F_PUSH;
			F_PUSH: begin
				if (!room || !busy_q[bank_q]) begin
					push    = 1'b1;
					wr      = room;
					state_d = last_q ? F_END : F_IDLE;
				end
			end
			F_END: begin
				if (!q_full) begin
					clear   = 1'b1;
					issue   = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// bank ownership
	always_comb begin
		busy_d = busy_q;
		if (rel.valid) busy_d[rel.bank] = 1'b0;
		if (issue && close_eval) busy_d[bank_q] = 1'b1;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= F_IDLE;
		else state_q <= state_d;
	end

	// scan and cluster state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q     <= 1'b1;
			beam_q      <= '0;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			sumx_q      <= '0;
			sumy_q      <= '0;
			bank_q      <= 1'b0;
			busy_q      <= '0;
		end else begin
			busy_q <= busy_d;
			if (accept) begin
				fresh_q <= 1'b0;
				beam_q  <= angle + cfg.angle_step;
			end
			if (clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				sumx_q  <= '0;
				sumy_q  <= '0;
				if (issue && close_eval) bank_q <= ~bank_q;
				if (state_q != F_SPLIT) have_prev_q <= 1'b0;
				if (state_q == F_END) fresh_q <= 1'b1;
			end
			if (push) begin
				if (wr) begin
					count_q <= count_q + CNT_W'(1);
					sumx_q  <= sumx_q + SUM_W'(x_q);
					sumy_q  <= sumy_q + SUM_W'(y_q);
				end else begin
					ovf_q <= 1'b1;
				end
				prev_x_q    <= x_q;
				prev_y_q    <= y_q;
				have_prev_q <= 1'b1;
			end
		end
	end

	// point datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			range_q <= in_range;
			last_q  <= in_scan_end;
			c_q     <= CORDIC_GAIN;
			s_q     <= '0;
			it_q    <= '0;
			if (z0 > 26'sd4194304) begin
				z_q    <= z0 - 26'sd8388608;
				flip_q <= 1'b1;
			end else if (z0 < -26'sd4194304) begin
				z_q    <= z0 + 26'sd8388608;
				flip_q <= 1'b1;
			end else begin
				z_q    <= z0;
				flip_q <= 1'b0;
			end
		end
		case (state_q)
			F_ROT: begin
				if (!z_q[25]) begin
					c_q <= c_q - dc;
					s_q <= s_q + ds;
					z_q <= z_q - at;
				end else begin
					c_q <= c_q + dc;
					s_q <= s_q - ds;
					z_q <= z_q + at;
				end
				it_q <= it_q + 5'd1;
			end
			F_MUL: begin
				pc_q <= $signed({1'b0, range_q}) * cf;
				ps_q <= $signed({1'b0, range_q}) * sf;
			end
			F_RND: begin
				x_q  <= round30(pc_q);
				y_q  <= round30(ps_q);
				jj_q <= cfg.jump_limit_mm * cfg.jump_limit_mm;
			end
			F_DIST: begin
				dx2_q <= 36'(dx * dx);
				dy2_q <= 36'(dy * dy);
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/lscd_back.sv
// ----------------------------------------------------------------------------
// lscd_back
// Evaluates closed clusters: centroid by a shared serial divider, point radii
// by a serial square root, then the radial variance test and result output.
// ----------------------------------------------------------------------------
module lscd_back import lscd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        variance_limit,
	input  logic               q_empty,
	input  cmd_t               q_head,
	output logic               q_pop,
	output rel_t               rel,
	output logic [ADDR_W-1:0]  ram_raddr,
	input  logic [POINT_W-1:0] ram_rdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_found,
	output logic signed [16:0] out_x,
	output logic signed [16:0] out_y,
	output logic [CNT_W-1:0]   out_total,
	output logic               out_done
);

	localparam logic [2:0] JOB_CX4  = 3'd0;
	localparam logic [2:0] JOB_CY4  = 3'd1;
	localparam logic [2:0] JOB_CX   = 3'd2;
	localparam logic [2:0] JOB_CY   = 3'd3;
	localparam logic [2:0] JOB_MEAN = 3'd4;

	back_state_t state_q, state_d;

	cmd_t               cmd_q;
	logic [2:0]         job_q;
	logic [31:0]        dvd_q;
	logic [8:0]         rem_q;
	logic [4:0]         dcnt_q;
	logic signed [21:0] cx4_q, cy4_q;
	logic signed [16:0] cx_q, cy_q;
	logic [21:0]        mean_q;
	logic               pass_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [22:0] dx_q, dy_q;
	logic [43:0]        dx2_q, dy2_q;
	logic [43:0]        sv_q;
	logic [23:0]        srem_q;
	logic [21:0]        root_q;
	logic [4:0]         scnt_q;
	logic [31:0]        sumr_q;
	logic [21:0]        d_q;
	logic [52:0]        acc_q;
	logic [40:0]        lim_q;
	logic               ok_q;
	logic               hold_v_q;
	logic signed [16:0] hold_x_q, hold_y_q;
	logic [CNT_W-1:0]   hold_n_q;
	logic               ov_q;

	logic [CNT_W-1:0]   n;
	logic [24:0]        magx, magy;
	logic [31:0]        half;
	logic [9:0]         r2, rdiff;
	logic               ge;
	logic [31:0]        quo;
	logic               qneg;
	logic [25:0]        r4, trial;
	logic               sge;
	logic signed [16:0] rd_x, rd_y;
	logic               idx_last, out_free;
	logic [43:0]        dsq;
	back_state_t        next_end;

	function automatic logic [31:0] operand(input logic [2:0] job, input logic [24:0] mx,
		input logic [24:0] my, input logic [31:0] sr, input logic [31:0] h);
		logic [31:0] v;
		case (job)
			JOB_CX4:  v = {3'd0, mx, 4'd0} + h;
			JOB_CY4:  v = {3'd0, my, 4'd0} + h;
			JOB_CX:   v = {7'd0, mx} + h;
			JOB_CY:   v = {7'd0, my} + h;
			JOB_MEAN: v = sr + h;
			default:  v = '0;
		endcase
		return v;
	endfunction

	assign n    = cmd_q.n;
	assign half = {24'd0, n[CNT_W-1:1]};
	assign magx = cmd_q.sum_x[SUM_W-1] ? 25'(-cmd_q.sum_x) : 25'(cmd_q.sum_x);
	assign magy = cmd_q.sum_y[SUM_W-1] ? 25'(-cmd_q.sum_y) : 25'(cmd_q.sum_y);

	// divider step
	assign r2    = {rem_q, dvd_q[31]};
	assign rdiff = r2 - {1'b0, n};
	assign ge    = r2 >= {1'b0, n};
	assign quo   = {dvd_q[30:0], ge};
	assign qneg  = (job_q == JOB_CX4 || job_q == JOB_CX) ? cmd_q.sum_x[SUM_W-1]
	                                                     : cmd_q.sum_y[SUM_W-1];

	// square root step
	assign r4    = {srem_q, sv_q[43:42]};
	assign trial = {2'd0, root_q, 2'b01};
	assign sge   = r4 >= trial;

	// squared radius deviation
	assign dsq = d_q * d_q;

	assign rd_x      = $signed(ram_rdata[COORD_W-1:0]);
	assign rd_y      = $signed(ram_rdata[POINT_W-1:COORD_W]);
	assign idx_last  = ({1'b0, idx_q} == (n - CNT_W'(1)));
	assign ram_raddr = {cmd_q.bank, idx_q};
	assign out_free  = !ov_q || out_ready;
	assign next_end  = cmd_q.is_end ? B_FIN : B_IDLE;
	assign out_valid = ov_q;

	// next state and control
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		rel      = '0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = q_head.eval ? B_START : B_FIN;
				end
			end
			B_START: state_d = B_DIV;
			B_DIV: begin
				if (dcnt_q == 5'd31 && (job_q == JOB_CY || job_q == JOB_MEAN)) begin
					state_d = B_RD;
				end
			end
			B_RD:   state_d = B_DIFF;
			B_DIFF: state_d = B_SQ;
			B_SQ:   state_d = B_SQI;
			B_SQI:  state_d = B_SQRT;
			B_SQRT: begin
				if (scnt_q == 5'd21) state_d = B_ACC;
			end
			B_ACC: begin
				if (pass_q) state_d = B_VSQ;
				else state_d = idx_last ? B_MEANL : B_RD;
			end
			B_VSQ:   state_d = idx_last ? B_LIM : B_RD;
			B_MEANL: state_d = B_DIV;
			B_LIM:   state_d = B_DEC;
			B_DEC: begin
				rel.valid = 1'b1;
				rel.bank  = cmd_q.bank;
				state_d   = B_POST;
			end
			B_POST: begin
				if (!ok_q || (cmd_q.item_end && !hold_v_q) || out_free) state_d = next_end;
			end
			B_FIN: begin
				if (out_free) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	// output register and held table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q     <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (out_ready) ov_q <= 1'b0;
			if (state_q == B_POST && ok_q) begin
				if (!cmd_q.item_end) begin
					if (out_free) ov_q <= 1'b1;
				end else if (!hold_v_q) begin
					hold_v_q <= 1'b1;
				end else if (out_free) begin
					ov_q <= 1'b1;
				end
			end
			if (state_q == B_FIN && out_free) begin
				ov_q     <= 1'b1;
				hold_v_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == B_POST && ok_q) begin
			if (!cmd_q.item_end) begin
				if (out_free) begin
					out_found <= 1'b1;
					out_x     <= cx_q;
					out_y     <= cy_q;
					out_total <= n;
					out_done  <= 1'b0;
				end
			end else if (!hold_v_q) begin
				hold_x_q <= cx_q;
				hold_y_q <= cy_q;
				hold_n_q <= n;
			end else if (out_free) begin
				// older table of this beam goes out, newer one waits
				out_found <= 1'b1;
				out_x     <= hold_x_q;
				out_y     <= hold_y_q;
				out_total <= hold_n_q;
				out_done  <= 1'b0;
				hold_x_q  <= cx_q;
				hold_y_q  <= cy_q;
				hold_n_q  <= n;
			end
		end
		if (state_q == B_FIN && out_free) begin
			out_found <= hold_v_q;
			out_x     <= hold_v_q ? hold_x_q : 17'sd0;
			out_y     <= hold_v_q ? hold_y_q : 17'sd0;
			out_total <= hold_v_q ? hold_n_q : '0;
			out_done  <= 1'b1;
		end
	end

	// cluster evaluation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_pop) cmd_q <= q_head;
			end
			B_START: begin
				job_q  <= JOB_CX4;
				dvd_q  <= operand(JOB_CX4, magx, magy, sumr_q, half);
				rem_q  <= '0;
				dcnt_q <= '0;
				sumr_q <= '0;
				acc_q  <= '0;
				pass_q <= 1'b0;
				idx_q  <= '0;
			end
			B_DIV: begin
				if (dcnt_q != 5'd31) begin
					dvd_q  <= quo;
					rem_q  <= ge ? rdiff[8:0] : r2[8:0];
					dcnt_q <= dcnt_q + 5'd1;
				end else begin
					case (job_q)
						JOB_CX4:  cx4_q  <= qneg ? -$signed(quo[21:0]) : $signed(quo[21:0]);
						JOB_CY4:  cy4_q  <= qneg ? -$signed(quo[21:0]) : $signed(quo[21:0]);
						JOB_CX:   cx_q   <= qneg ? -$signed(quo[16:0]) : $signed(quo[16:0]);
						JOB_CY:   cy_q   <= qneg ? -$signed(quo[16:0]) : $signed(quo[16:0]);
						JOB_MEAN: mean_q <= quo[21:0];
						default: ;
					endcase
					if (job_q == JOB_MEAN) begin
						pass_q <= 1'b1;
						idx_q  <= '0;
					end else if (job_q != JOB_CY) begin
						job_q  <= job_q + 3'd1;
						dvd_q  <= operand(job_q + 3'd1, magx, magy, sumr_q, half);
						rem_q  <= '0;
						dcnt_q <= '0;
					end
				end
			end
			B_DIFF: begin
				dx_q <= $signed({{2{rd_x[16]}}, rd_x, 4'd0}) - 23'(cx4_q);
				dy_q <= $signed({{2{rd_y[16]}}, rd_y, 4'd0}) - 23'(cy4_q);
			end
			B_SQ: begin
				dx2_q <= 44'(dx_q * dx_q);
				dy2_q <= 44'(dy_q * dy_q);
			end
			B_SQI: begin
				sv_q   <= dx2_q + dy2_q;
				srem_q <= '0;
				root_q <= '0;
				scnt_q <= '0;
			end
			B_SQRT: begin
				srem_q <= sge ? 24'(r4 - trial) : r4[23:0];
				root_q <= {root_q[20:0], sge};
				sv_q   <= {sv_q[41:0], 2'b00};
				scnt_q <= scnt_q + 5'd1;
			end
			B_ACC: begin
				if (!pass_q) begin
					sumr_q <= sumr_q + {10'd0, root_q};
					if (!idx_last) idx_q <= idx_q + IDX_W'(1);
				end else begin
					d_q <= (root_q >= mean_q) ? root_q - mean_q : mean_q - root_q;
				end
			end
			B_VSQ: begin
				acc_q <= acc_q + {9'd0, dsq};
				if (!idx_last) idx_q <= idx_q + IDX_W'(1);
			end
			B_MEANL: begin
				job_q  <= JOB_MEAN;
				dvd_q  <= operand(JOB_MEAN, magx, magy, sumr_q, half);
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			B_LIM: begin
				lim_q <= variance_limit * n;
			end
			B_DEC: begin
				ok_q <= acc_q < {4'd0, lim_q, 8'd0};
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/laser_scan_circle_cluster_detector.sv
// ----------------------------------------------------------------------------
// laser_scan_circle_cluster_detector
// Segments a lidar scan at breakpoints and reports round clusters as tables.
// ----------------------------------------------------------------------------
// Front: a sample outside the window closes the open cluster; a valid sample
// passes 24 CORDIC iterations, rounding, jump test and store write, with one
// more step on a scan end; it stalls while the queue is full or the next bank
// is in use. Back: per cluster five serial divisions and two passes over the
// point store, with a serial square root per point in each pass.
// Reset clears all control state; the point store is not cleared.
module laser_scan_circle_cluster_detector import lscd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [15:0]            s_tdata,  // [15:0] range_mm
	input  logic                   s_tuser,  // [0] sample_valid
	input  logic                   s_tlast,  // scan_end
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [47:0]            m_tdata,  // [16:0] centre_x_mm, [33:17] centre_y_mm,
	                                         // [42:34] point_total
	output logic                   m_tuser,  // [0] table_found
	output logic                   m_tlast,  // scan_done
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t               cfg_q;
	logic               q_push, q_full, q_pop, q_empty;
	cmd_t               q_cmd, q_head;
	rel_t               rel;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [POINT_W-1:0] ram_wdata, ram_rdata;
	logic signed [16:0] out_x, out_y;
	logic [CNT_W-1:0]   out_total;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jump_limit_mm      <= 16'd250;
			cfg_q.variance_limit_mm2 <= 32'd2500;
			cfg_q.range_floor_mm     <= 16'd0;
			cfg_q.range_ceiling_mm   <= 16'hFFFF;
			cfg_q.start_angle        <= 16'h8000;
			cfg_q.angle_step         <= 16'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_JUMP_LIMIT:     cfg_q.jump_limit_mm      <= cfg_data[15:0];
				REG_VARIANCE_LIMIT: cfg_q.variance_limit_mm2 <= cfg_data;
				REG_RANGE_FLOOR:    cfg_q.range_floor_mm     <= cfg_data[15:0];
				REG_RANGE_CEILING:  cfg_q.range_ceiling_mm   <= cfg_data[15:0];
				REG_START_ANGLE:    cfg_q.start_angle        <= cfg_data[15:0];
				REG_ANGLE_STEP:     cfg_q.angle_step         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	lscd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_range        (s_tdata),
		.in_sample_valid (s_tuser),
		.in_scan_end     (s_tlast),
		.q_push          (q_push),
		.q_cmd           (q_cmd),
		.q_full          (q_full),
		.rel             (rel),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata)
	);

	lscd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// two banks of cluster points
	lscd_ram #(
		.WIDTH (POINT_W),
		.DEPTH (RAM_DEPTH)
	) u_points (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lscd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.variance_limit (cfg_q.variance_limit_mm2),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.rel            (rel),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_found      (m_tuser),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_total      (out_total),
		.out_done       (m_tlast)
	);

	// result packing
	assign m_tdata = {5'd0, out_total, out_y, out_x};

endmodule

FILE: bench/lscd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lscd_checker
// Watches the sample, result and register ports of the cluster detector,
// predicts every result from each accepted sample and compares in order.
// ----------------------------------------------------------------------------
module lscd_checker import lscd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [15:0]            s_tdata,
	input  logic                   s_tuser,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [47:0]            m_tdata,
	input  logic                   m_tuser,
	input  logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     table_count,
	output int                     scan_count
);

	typedef struct packed {
		logic               found;
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic [8:0]         total;
		logic               done;
	} table_rpt_t;

	localparam longint PHASE_HALF = 64'sd1 << 23;

	// per-step arctangent, 1/2^24 turn
	longint atan_lut [24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
		20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

	cfg_t        regs;
	bit [15:0]   beam_angle;
	bit          scan_fresh;
	int          prev_x, prev_y;
	bit          have_prev;
	int          pts_x [MAX_CLUSTER];
	int          pts_y [MAX_CLUSTER];
	int          pt_count;
	bit          pt_overflow;
	longint      sum_x, sum_y;
	table_rpt_t  table_q[$];
	table_rpt_t  step_q[$];

	assign pending = table_q.size();

	function automatic longint mag_round_shift(longint v, int sh);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 << (sh - 1))) >>> sh;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint div_nearest(longint num, longint den);
		longint m;
		m = (num < 0) ? -num : num;
		m = (m + den / 2) / den;
		return (num < 0) ? -m : m;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// polar to cartesian through the rotation iterations
	task automatic polar_to_xy(input longint rng, input bit [15:0] ang,
		output int px, output int py);
		longint z, c, s, dc, ds;
		bit flip;
		z = longint'(ang) << 8;
		if (z >= PHASE_HALF) z = z - (64'sd1 << 24);
		c = 652032873;
		s = 0;
		flip = 0;
		if (z > (64'sd1 << 22)) begin
			z = z - PHASE_HALF;
			flip = 1;
		end else if (z < -(64'sd1 << 22)) begin
			z = z + PHASE_HALF;
			flip = 1;
		end
		for (int i = 0; i < 24; i++) begin
			dc = s >>> i;
			ds = c >>> i;
			if (z >= 0) begin
				c = c - dc; s = s + ds; z = z - atan_lut[i];
			end else begin
				c = c + dc; s = s - ds; z = z + atan_lut[i];
			end
		end
		if (flip) begin
			c = -c; s = -s;
		end
		px = int'(mag_round_shift(rng * c, 30));
		py = int'(mag_round_shift(rng * s, 30));
	endtask

	function automatic longint unsigned radius16(int i, longint cx, longint cy);
		longint dx, dy;
		dx = longint'(pts_x[i]) * 16 - cx;
		dy = longint'(pts_y[i]) * 16 - cy;
		return floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
	endfunction

	// round-cluster test on the closed cluster
	task automatic close_cluster();
		longint cx, cy;
		longint unsigned sum_r, mean, acc, d, sq, lim;
		table_rpt_t t;
		if (!pt_overflow && pt_count >= 2) begin
			cx = div_nearest(sum_x * 16, pt_count);
			cy = div_nearest(sum_y * 16, pt_count);
			sum_r = 0;
			for (int i = 0; i < pt_count; i++) sum_r += radius16(i, cx, cy);
			mean = (sum_r + pt_count / 2) / pt_count;
			acc = 0;
			for (int i = 0; i < pt_count; i++) begin
				d = radius16(i, cx, cy);
				d = (d >= mean) ? d - mean : mean - d;
				sq = d * d;
				acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
			end
			lim = longint'(regs.variance_limit_mm2) * pt_count * 256;
			if (acc < lim) begin
				t.found = 1;
				t.x = 17'(div_nearest(sum_x, pt_count));
				t.y = 17'(div_nearest(sum_y, pt_count));
				t.total = 9'(pt_count);
				t.done = 0;
				step_q = {step_q, t};
			end
		end
		pt_count = 0;
		pt_overflow = 0;
		sum_x = 0;
		sum_y = 0;
	endtask

	// one accepted sample
	task automatic predict_sample(input bit [15:0] rng, input bit ok, input bit last);
		bit [15:0] ang;
		int x, y;
		longint dx, dy;
		table_rpt_t t;
		step_q.delete();
		ang = scan_fresh ? regs.start_angle : beam_angle;
		if (!ok || rng < regs.range_floor_mm || rng > regs.range_ceiling_mm) begin
			close_cluster();
			have_prev = 0;
		end else begin
			polar_to_xy(longint'(rng), ang, x, y);
			if (have_prev) begin
				dx = x - prev_x;
				dy = y - prev_y;
				if (dx * dx + dy * dy > longint'(regs.jump_limit_mm) * regs.jump_limit_mm)
					close_cluster();
			end
			if (pt_count < MAX_CLUSTER) begin
				pts_x[pt_count] = x;
				pts_y[pt_count] = y;
				pt_count++;
				sum_x += x;
				sum_y += y;
			end else begin
				pt_overflow = 1;
			end
			prev_x = x;
			prev_y = y;
			have_prev = 1;
		end
		beam_angle = ang + regs.angle_step;
		scan_fresh = 0;
		if (last) begin
			close_cluster();
			have_prev = 0;
			scan_fresh = 1;
			scan_count++;
			if (step_q.size() > 0) begin
				step_q[step_q.size() - 1].done = 1;
			end else begin
				t = '0;
				t.done = 1;
				step_q = {step_q, t};
			end
		end
		table_q = {table_q, step_q};
	endtask

	// register writes, sample and result transactions
	always @(posedge clk or negedge arst_n) begin
		table_rpt_t got, want;
		if (!arst_n) begin
			regs.jump_limit_mm      = 16'd250;
			regs.variance_limit_mm2 = 32'd2500;
			regs.range_floor_mm     = 16'd0;
			regs.range_ceiling_mm   = 16'hFFFF;
			regs.start_angle        = 16'h8000;
			regs.angle_step         = 16'd64;
			beam_angle  = 0;
			scan_fresh  = 1;
			prev_x      = 0;
			prev_y      = 0;
			have_prev   = 0;
			pt_count    = 0;
			pt_overflow = 0;
			sum_x       = 0;
			sum_y       = 0;
			table_q.delete();
			fail_count  = 0;
			table_count = 0;
			scan_count  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_JUMP_LIMIT:     regs.jump_limit_mm      = cfg_data[15:0];
					REG_VARIANCE_LIMIT: regs.variance_limit_mm2 = cfg_data;
					REG_RANGE_FLOOR:    regs.range_floor_mm     = cfg_data[15:0];
					REG_RANGE_CEILING:  regs.range_ceiling_mm   = cfg_data[15:0];
					REG_START_ANGLE:    regs.start_angle        = cfg_data[15:0];
					REG_ANGLE_STEP:     regs.angle_step         = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_sample(s_tdata, s_tuser, s_tlast);
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.x     = m_tdata[16:0];
				got.y     = m_tdata[33:17];
				got.total = m_tdata[42:34];
				got.done  = m_tlast;
				if (got.found) table_count++;
				if (table_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result transaction: expected none, actual %p",
						$time, got);
				end else begin
					want = table_q.pop_front();
					if (got.found !== want.found || got.x !== want.x || got.y !== want.y ||
						got.total !== want.total || got.done !== want.done) begin
						fail_count++;
						$display("%0t: result mismatch: expected %p, actual %p",
							$time, want, got);
					end
				end
			end
		end
	end

endmodule

FILE: bench/tb_laser_scan_circle_cluster_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laser_scan_circle_cluster_detector
// Drives lidar scans (directed corners, a store overflow, then random scans
// built from short arcs, jumps and dropouts) under several register settings
// with random idling on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_laser_scan_circle_cluster_detector;
	import lscd_pkg::*;

	localparam int     BACK_DRAIN = 16000;
	localparam longint CYCLE_LIMIT = 4000000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [15:0]            s_tdata;
	logic                   s_tuser;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [47:0]            m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     fail_count, pending, table_count, scan_count;
	bit                     calm;
	int                     rx_stall;
	int                     samples_sent;
	longint                 cycles;

	laser_scan_circle_cluster_detector uut (.*);

	lscd_checker chk (.*);

	initial clk = 0;
	always #10 clk = ~clk;

	// receiver back-pressure, drawn per result transaction
	initial rx_stall = 0;
	always @(posedge clk) begin
		int gap;
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 0;
		end else if (m_tvalid && m_tready && !calm) begin
			gap = $urandom_range(0, 12);
			rx_stall <= (gap > 0) ? gap - 1 : 0;
			m_tready <= (gap == 0);
		end else begin
			m_tready <= 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("laser_scan_circle_cluster_detector verification failed");
			$finish;
		end
	end

	task automatic send_sample(input bit [15:0] rng, input bit ok, input bit last);
		int gap;
		s_tdata  <= rng;
		s_tuser  <= ok;
		s_tlast  <= last;
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		samples_sent++;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (BACK_DRAIN) @(posedge clk);
	endtask

	task automatic write_regs(input bit [15:0] jump, input bit [31:0] var_lim,
		input bit [15:0] floor_v, input bit [15:0] ceil_v,
		input bit [15:0] ang0, input bit [15:0] step);
		cfg_we <= 1;
		cfg_index <= REG_JUMP_LIMIT;     cfg_data <= {16'd0, jump};    @(posedge clk);
		cfg_index <= REG_VARIANCE_LIMIT; cfg_data <= var_lim;          @(posedge clk);
		cfg_index <= REG_RANGE_FLOOR;    cfg_data <= {16'd0, floor_v}; @(posedge clk);
		cfg_index <= REG_RANGE_CEILING;  cfg_data <= {16'd0, ceil_v};  @(posedge clk);
		cfg_index <= REG_START_ANGLE;    cfg_data <= {16'd0, ang0};    @(posedge clk);
		cfg_index <= REG_ANGLE_STEP;     cfg_data <= {16'd0, step};    @(posedge clk);
		cfg_index <= 8'hFF;              cfg_data <= '1;               @(posedge clk);
		cfg_we <= 0;
	endtask

	// one scan of short arcs, jumps, dropouts and stray ranges
	task automatic random_scan(input int len);
		int base, pick, r;
		base = $urandom_range(300, 9000);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_sample(16'($urandom), 0, i == len - 1);
			end else if (pick < 13) begin
				send_sample(16'($urandom), 1, i == len - 1);
			end else begin
				if (pick < 22) base = $urandom_range(300, 9000);
				r = base + $urandom_range(0, 8) - 4;
				send_sample(r[15:0], 1, i == len - 1);
			end
		end
	endtask

	task automatic random_phase(input int items);
		int n;
		n = 0;
		while (n < items) begin
			calm = ($urandom_range(0, 5) == 0);
			random_scan($urandom_range(4, 24));
			n = samples_sent;
		end
	endtask

	initial begin
		int target;
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0; s_tlast = 0;
		m_tready = 0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		calm = 0;
		cycles = 0;
		samples_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed, reset settings: range extremes, dropouts, jumps, scan ends
		send_sample(16'd0, 1, 0);
		send_sample(16'hFFFF, 1, 0);
		send_sample(16'h5555, 0, 0);
		send_sample(16'd2000, 1, 0);
		send_sample(16'd2001, 1, 1);
		send_sample(16'd3000, 1, 1);
		send_sample(16'hAAAA, 0, 1);
		send_sample(16'd1000, 1, 0);
		send_sample(16'd1002, 1, 0);
		send_sample(16'd6000, 1, 0);
		send_sample(16'd6001, 1, 0);
		send_sample(16'd6003, 1, 1);
		send_sample(16'd4000, 1, 1);
		settle();

		// extremes: no jump tolerance, zero variance, reversed half-turn steps
		write_regs(16'd0, 32'd0, 16'd0, 16'hFFFF, 16'h7FFF, 16'h8000);
		send_sample(16'd1500, 1, 0);
		send_sample(16'd1500, 1, 0);
		send_sample(16'd1500, 1, 1);
		settle();

		// wide open limits, narrow window
		write_regs(16'hFFFF, 32'hFFFF_FFFF, 16'd1000, 16'd6000, 16'h0000, 16'h7FFF);
		send_sample(16'd999, 1, 0);
		send_sample(16'd1000, 1, 0);
		send_sample(16'd6000, 1, 0);
		send_sample(16'd6001, 1, 0);
		send_sample(16'd3000, 1, 0);
		send_sample(16'd3500, 1, 1);
		settle();

		// store overflow: one fixed beam repeated past the store depth
		write_regs(16'd250, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 16'h1234, 16'd0);
		calm = 1;
		for (int i = 0; i < MAX_CLUSTER + 2; i++)
			send_sample(16'd5000, 1, i == MAX_CLUSTER + 1);
		calm = 0;
		settle();

		// random phases under several settings
		target = samples_sent;
		write_regs(16'd250, 32'd2500, 16'd0, 16'hFFFF, 16'h8000, 16'd64);
		random_phase(target + 30);
		// hold off the sender until the results drain
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		random_phase(samples_sent + 20);
		settle();
		write_regs(16'd40, 32'd400, 16'd200, 16'd12000, 16'h4000, 16'hFFC0);
		random_phase(samples_sent + 40);
		settle();
		write_regs(16'd1200, 32'd200000, 16'd500, 16'd8000, 16'($urandom), 16'd3);
		random_phase(samples_sent + 40);
		settle();
		write_regs(16'($urandom_range(100, 600)), 32'($urandom_range(1000, 90000)),
			16'($urandom_range(0, 400)), 16'($urandom_range(8000, 65535)),
			16'($urandom), 16'($urandom_range(0, 400) - 200));
		random_phase(samples_sent + 40);
		settle();

		$display("Sent %0d samples over %0d scans under several register settings,",
			samples_sent, scan_count);
		$display("including a store overflow; %0d table results seen.", table_count);
		if (fail_count == 0)
			$display("laser_scan_circle_cluster_detector verification clean");
		else
			$display("laser_scan_circle_cluster_detector verification failed");
		$finish;
	end

endmodule
